@@ hdl/wbps_pkg.sv @@
// ============================================================================
// wbps_pkg: shared types and constants for the wildcard byte pattern search
// Register map, fixed field widths and the stage-one control bundle.
// ============================================================================
`timescale 1ns / 1ps

package wbps_pkg;

    // Default sizing, handed to the top-level parameters
    localparam int DEF_MAX_PATTERN    = 32;
    localparam int DEF_BYTES_PER_WORD = 8;
    localparam int DEF_OFFSET_BITS    = 32;

    // Fixed port widths
    localparam int DATA_W      = 64;
    localparam int COUNT_W     = 4;
    localparam int OUT_OFF_W   = 32;
    localparam int PAT_WORDS   = 4;
    localparam int CARE_W      = 32;
    localparam int LENGTH_W    = 6;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_MID    = 3'd1,
        REG_PATTERN_UPPER  = 3'd2,
        REG_PATTERN_TOP    = 3'd3,
        REG_CARE_BITS      = 3'd4,
        REG_PATTERN_LENGTH = 3'd5
    } cfg_reg_t;

    // Control carried from the lane stage into the merge stage
    typedef struct packed {
        logic valid;
        logic last;
        logic sat;
    } s1_ctl_t;

endpackage

@@ hdl/wbps_lane.sv @@
// ============================================================================
// wbps_lane: one match lane
// Checks whether the pattern ends at one fixed byte position of the word,
// and whether that byte's offset may legally end a match.
// ============================================================================
`timescale 1ns / 1ps

module wbps_lane #(
    parameter int MAX_PATTERN    = 32,
    parameter int BYTES_PER_WORD = 8,
    parameter int OFFSET_BITS    = 32,
    parameter int LANE           = 0
) (
    input  logic [7:0]                             stream [MAX_PATTERN],
    input  logic [7:0]                             apat   [MAX_PATTERN],
    input  logic [MAX_PATTERN-1:0]                 acare,
    input  logic [$clog2(BYTES_PER_WORD+1)-1:0]    count,
    input  logic [OFFSET_BITS-1:0]                 base,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]       len,
    output logic                                   hit
);
    import wbps_pkg::*;

    localparam int CNT_BITS = $clog2(BYTES_PER_WORD + 1);
    localparam int OW1      = OFFSET_BITS + 1;
    localparam logic [OW1-1:0] OFFSET_MAX = {1'b0, {OFFSET_BITS{1'b1}}};
    localparam logic [OW1-1:0] LANE_OFF   = OW1'(LANE);

    logic [MAX_PATTERN-1:0] byte_ok;
    logic [OW1-1:0]         idx;
    logic [OW1-1:0]         idx_end;
    logic                   in_word;
    logic                   counted;
    logic                   long_enough;

    // Per-age compare; ages past the length are never cared for
    always_comb
    begin
        for (int a = 0; a < MAX_PATTERN; a++)
        begin
            byte_ok[a] = !acare[a] || (stream[a] == apat[a]);
        end
    end

    // Offset checks for the byte that ends the candidate match
    assign idx         = {1'b0, base} + LANE_OFF;
    assign idx_end     = idx + OW1'(1);
    assign in_word     = CNT_BITS'(LANE) < count;
    assign counted     = idx < OFFSET_MAX;
    assign long_enough = idx_end >= OW1'(len);

    assign hit = in_word && counted && long_enough && (&byte_ok);

endmodule

@@ hdl/wbps_merge.sv @@
// ============================================================================
// wbps_merge: lane merge and result register
// Picks the lowest hitting lane, keeps the first match of the range and
// drives the result on the word marked last.
// ============================================================================
`timescale 1ns / 1ps

module wbps_merge #(
    parameter int MAX_PATTERN    = 32,
    parameter int BYTES_PER_WORD = 8,
    parameter int OFFSET_BITS    = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wbps_pkg::s1_ctl_t                    s1_ctl,
    input  logic [BYTES_PER_WORD-1:0]            s1_hits,
    input  logic [OFFSET_BITS-1:0]               s1_base,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]     s1_len,
    input  logic                                 out_stall,
    output logic                                 take,
    output logic                                 out_valid,
    output logic                                 found,
    output logic [wbps_pkg::OUT_OFF_W-1:0]       match_offset,
    output logic                                 range_too_long
);
    import wbps_pkg::*;

    localparam int SEL_W = (BYTES_PER_WORD > 1) ? $clog2(BYTES_PER_WORD) : 1;
    localparam int OW    = OFFSET_BITS;

    logic          match_seen_reg, match_seen_next;
    logic [OW-1:0] first_off_reg,  first_off_next;
    logic          sat_reg,        sat_next;
    logic          out_valid_reg;
    logic          found_reg;
    logic [OUT_OFF_W-1:0] offset_reg;
    logic          too_long_reg;

    logic [SEL_W-1:0]           sel;
    logic                       any_hit;
    logic [OW-1:0]              cand_off;
    logic [OW+OUT_OFF_W-1:0]    off_wide;

    // Merge may consume unless a finished result is still held
    assign take = s1_ctl.valid && (!s1_ctl.last || !out_valid_reg || !out_stall);

    // Lowest hitting lane wins
    always_comb
    begin
        sel = '0;
        for (int l = BYTES_PER_WORD - 1; l >= 0; l--)
        begin
            if (s1_hits[l])
            begin
                sel = SEL_W'(l);
            end
        end
    end

    assign any_hit  = |s1_hits;
    assign cand_off = s1_base + OW'(sel) + OW'(1) - OW'(s1_len);

    // Range accumulation
    always_comb
    begin
        match_seen_next = match_seen_reg || any_hit;
        first_off_next  = (!match_seen_reg && any_hit) ? cand_off : first_off_reg;
        sat_next        = sat_reg || s1_ctl.sat;
    end

    // Result fits the 32-bit field; wider offsets are masked
    assign off_wide = {{OUT_OFF_W{1'b0}}, first_off_next};

    // Range state, cleared after the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_seen_reg <= 1'b0;
            first_off_reg  <= '0;
            sat_reg        <= 1'b0;
        end
        else if (take)
        begin
            if (s1_ctl.last)
            begin
                match_seen_reg <= 1'b0;
                first_off_reg  <= '0;
                sat_reg        <= 1'b0;
            end
            else
            begin
                match_seen_reg <= match_seen_next;
                first_off_reg  <= first_off_next;
                sat_reg        <= sat_next;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take && s1_ctl.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && s1_ctl.last)
        begin
            found_reg    <= match_seen_next;
            offset_reg   <= match_seen_next ? off_wide[OUT_OFF_W-1:0] : '0;
            too_long_reg <= sat_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign match_offset   = offset_reg;
    assign range_too_long = too_long_reg;

endmodule

@@ hdl/wildcard_byte_pattern_search_top.sv @@
// ============================================================================
// wildcard_byte_pattern_search_top: masked byte signature scan, eight lanes
// Path: a taken last word passes the lane stage register, then the result
// register; it waits in the lane stage while an earlier result is held.
// Throughput: one word per cycle unless stalled; all lanes compare in parallel.
// Input stalls only while a result waits and another last word is merging.
// Reset: async clear of config, control and range state; pattern zero, length
// one, no sweep; result data and lane stage data registers are not reset.
// ============================================================================
`timescale 1ns / 1ps

module wildcard_byte_pattern_search_top #(
    parameter int MAX_PATTERN    = wbps_pkg::DEF_MAX_PATTERN,
    parameter int BYTES_PER_WORD = wbps_pkg::DEF_BYTES_PER_WORD,
    parameter int OFFSET_BITS    = wbps_pkg::DEF_OFFSET_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [wbps_pkg::DATA_W-1:0]          data_word,
    input  logic [wbps_pkg::COUNT_W-1:0]         byte_count,
    input  logic                                 last,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 found,
    output logic [wbps_pkg::OUT_OFF_W-1:0]       match_offset,
    output logic                                 range_too_long
);
    import wbps_pkg::*;

    localparam int WIN      = MAX_PATTERN - 1;
    localparam int CNT_BITS = $clog2(BYTES_PER_WORD + 1);
    localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);
    localparam int PIDX_W   = $clog2(MAX_PATTERN);
    localparam int OW       = OFFSET_BITS;
    localparam int OW1      = OFFSET_BITS + 1;
    localparam logic [OW1-1:0] OFFSET_MAX = {1'b0, {OFFSET_BITS{1'b1}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PAT_WORDS*DATA_W-1:0] pat_reg,  pat_next;
    logic [CARE_W-1:0]           care_reg, care_next;
    logic [LEN_BITS-1:0]         len_reg,  len_next;
    logic [LENGTH_W-1:0]         len_raw;
    logic [7:0]                  apat_reg  [MAX_PATTERN];
    logic [7:0]                  apat_next [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]      acare_reg, acare_next;

    assign len_raw = cfg_data[LENGTH_W-1:0];

    // Register writes; zero length acts as one, long lengths saturate
    always_comb
    begin
        pat_next  = pat_reg;
        care_next = care_reg;
        len_next  = len_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LOW:    pat_next[0*DATA_W +: DATA_W] = cfg_data;
                REG_PATTERN_MID:    pat_next[1*DATA_W +: DATA_W] = cfg_data;
                REG_PATTERN_UPPER:  pat_next[2*DATA_W +: DATA_W] = cfg_data;
                REG_PATTERN_TOP:    pat_next[3*DATA_W +: DATA_W] = cfg_data;
                REG_CARE_BITS:      care_next = cfg_data[CARE_W-1:0];
                REG_PATTERN_LENGTH:
                begin
                    if (len_raw == '0)
                    begin
                        len_next = LEN_BITS'(1);
                    end
                    else if (len_raw > LENGTH_W'(MAX_PATTERN))
                    begin
                        len_next = LEN_BITS'(MAX_PATTERN);
                    end
                    else
                    begin
                        len_next = len_raw[LEN_BITS-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // Pattern laid out by age: age a compares against byte len-1-a
    always_comb
    begin
        logic [LEN_BITS-1:0] jl;
        logic [PIDX_W-1:0]   j;
        for (int a = 0; a < MAX_PATTERN; a++)
        begin
            jl = len_next - LEN_BITS'(1) - LEN_BITS'(a);
            j  = jl[PIDX_W-1:0];
            apat_next[a]  = pat_next[j*8 +: 8];
            acare_next[a] = (LEN_BITS'(a) < len_next) && care_next[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg   <= '0;
            care_reg  <= '0;
            len_reg   <= LEN_BITS'(1);
            acare_reg <= '0;
            for (int a = 0; a < MAX_PATTERN; a++)
            begin
                apat_reg[a] <= '0;
            end
        end
        else if (cfg_we)
        begin
            pat_reg   <= pat_next;
            care_reg  <= care_next;
            len_reg   <= len_next;
            acare_reg <= acare_next;
            apat_reg  <= apat_next;
        end
    end

    // ------------------------------------------------------------------
    // Input word, byte window and byte counter
    // ------------------------------------------------------------------
    logic [7:0]          wb       [BYTES_PER_WORD];
    logic [7:0]          win_reg  [WIN];
    logic [7:0]          win_next [WIN];
    logic [7:0]          win_cand [WIN][BYTES_PER_WORD+1];
    logic [CNT_BITS-1:0] cnt;
    logic [OW-1:0]       bs_reg, bs_next;
    logic [OW1-1:0]      bs_sum;
    logic                word_sat;
    logic                accept;
    logic                merge_take;

    // Lane stage contents
    s1_ctl_t                   s1_ctl_reg;
    logic [BYTES_PER_WORD-1:0] s1_hits_reg;
    logic [OW-1:0]             s1_base_reg;
    logic [LEN_BITS-1:0]       s1_len_reg;

    for (genvar gb = 0; gb < BYTES_PER_WORD; gb++)
    begin : g_bytes
        assign wb[gb] = data_word[gb*8 +: 8];
    end

    // Clamp byte count to the word size
    assign cnt = (byte_count > COUNT_W'(BYTES_PER_WORD)) ?
                 CNT_BITS'(BYTES_PER_WORD) : byte_count[CNT_BITS-1:0];

    // Window after shifting in c bytes, newest first
    for (genvar gk = 0; gk < WIN; gk++)
    begin : g_win
        for (genvar gc = 0; gc <= BYTES_PER_WORD; gc++)
        begin : g_cnt
            if (gc == 0)
            begin : g_none
                assign win_cand[gk][gc] = win_reg[gk];
            end
            else if (gk < gc)
            begin : g_new
                assign win_cand[gk][gc] = wb[gc-1-gk];
            end
            else
            begin : g_old
                assign win_cand[gk][gc] = win_reg[gk-gc];
            end
        end
        assign win_next[gk] = win_cand[gk][cnt];
    end

    // Saturating byte counter
    assign bs_sum   = {1'b0, bs_reg} + OW1'(cnt);
    assign word_sat = bs_sum > OFFSET_MAX;
    assign bs_next  = (bs_sum >= OFFSET_MAX) ? OFFSET_MAX[OW-1:0] : bs_sum[OW-1:0];

    assign in_stall = s1_ctl_reg.valid && !merge_take;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg <= '0;
            for (int k = 0; k < WIN; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (accept)
        begin
            if (last)
            begin
                bs_reg <= '0;
                for (int k = 0; k < WIN; k++)
                begin
                    win_reg[k] <= '0;
                end
            end
            else
            begin
                bs_reg  <= bs_next;
                win_reg <= win_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Match lanes, one per byte position of the word
    // ------------------------------------------------------------------
    logic [7:0]                lane_bytes [BYTES_PER_WORD][MAX_PATTERN];
    logic [BYTES_PER_WORD-1:0] hit_vec;

    for (genvar gl = 0; gl < BYTES_PER_WORD; gl++)
    begin : g_lane
        for (genvar ga = 0; ga < MAX_PATTERN; ga++)
        begin : g_age
            if (ga <= gl)
            begin : g_word
                assign lane_bytes[gl][ga] = wb[gl-ga];
            end
            else
            begin : g_hist
                assign lane_bytes[gl][ga] = win_reg[ga-gl-1];
            end
        end

        wbps_lane #(
            .MAX_PATTERN    (MAX_PATTERN),
            .BYTES_PER_WORD (BYTES_PER_WORD),
            .OFFSET_BITS    (OFFSET_BITS),
            .LANE           (gl)
        ) u_lane (
            .stream (lane_bytes[gl]),
            .apat   (apat_reg),
            .acare  (acare_reg),
            .count  (cnt),
            .base   (bs_reg),
            .len    (len_reg),
            .hit    (hit_vec[gl])
        );
    end

    // ------------------------------------------------------------------
    // Lane stage register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
        end
        else if (accept)
        begin
            s1_ctl_reg.valid <= 1'b1;
            s1_ctl_reg.last  <= last;
            s1_ctl_reg.sat   <= word_sat;
        end
        else if (merge_take)
        begin
            s1_ctl_reg.valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_hits_reg <= hit_vec;
            s1_base_reg <= bs_reg;
            s1_len_reg  <= len_reg;
        end
    end

    // ------------------------------------------------------------------
    // Merge and result
    // ------------------------------------------------------------------
    wbps_merge #(
        .MAX_PATTERN    (MAX_PATTERN),
        .BYTES_PER_WORD (BYTES_PER_WORD),
        .OFFSET_BITS    (OFFSET_BITS)
    ) u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .s1_ctl         (s1_ctl_reg),
        .s1_hits        (s1_hits_reg),
        .s1_base        (s1_base_reg),
        .s1_len         (s1_len_reg),
        .out_stall      (out_stall),
        .take           (merge_take),
        .out_valid      (out_valid),
        .found          (found),
        .match_offset   (match_offset),
        .range_too_long (range_too_long)
    );

`ifndef SYNTHESIS
    // Input only backs up behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // A result appears only after a last word passed the merge
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s1_ctl_reg.valid && s1_ctl_reg.last))
        else $error("result without a last word");

    // No match means a zero offset
    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (match_offset == '0))
        else $error("offset nonzero without a match");
`endif

endmodule

@@ tb/wbps_scan_checker.sv @@
// ============================================================================
// wbps_scan_checker: result predictor and scoreboard for the pattern search
// Watches config writes and both transfer channels, keeps its own copy of the
// scan state, predicts one verdict per range and compares every result.
// ============================================================================
`timescale 1ns / 1ps

module wbps_scan_checker
    import wbps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [DATA_W-1:0]      data_word,
    input  logic [COUNT_W-1:0]     byte_count,
    input  logic                   last,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic                   found,
    input  logic [OUT_OFF_W-1:0]   match_offset,
    input  logic                   range_too_long,
    output int                     results_due,
    output int                     results_checked,
    output int                     hits_seen,
    output int                     mismatches
);

    localparam int SIG_MAX   = DEF_MAX_PATTERN;
    localparam int LANES     = DEF_BYTES_PER_WORD;
    localparam int HIST_LEN  = SIG_MAX - 1;

    typedef struct {
        logic                 hit;
        logic [OUT_OFF_W-1:0] offset;
        logic                 too_long;
    } scan_verdict_t;

    // configuration copy
    logic [DATA_W-1:0]   sig_words [0:PAT_WORDS-1];
    logic [CARE_W-1:0]   care_mask;
    logic [LENGTH_W-1:0] sig_len_reg;

    // range state
    logic [7:0]                      history [0:HIST_LEN-1];
    logic [DEF_OFFSET_BITS-1:0]      bytes_counted;
    logic                            hit;
    logic [DEF_OFFSET_BITS-1:0]      hit_offset;
    logic                            saturated;

    scan_verdict_t verdicts_pending [$];

    initial
    begin
        results_due     = 0;
        results_checked = 0;
        hits_seen       = 0;
        mismatches      = 0;
    end

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    function automatic int unsigned sig_len_used();
        if (sig_len_reg == 0)
            return 1;
        if (sig_len_reg > SIG_MAX)
            return SIG_MAX;
        return sig_len_reg;
    endfunction

    function automatic logic [7:0] sig_byte(input int unsigned j);
        return sig_words[j / 8][8 * (j % 8) +: 8];
    endfunction

    task automatic clear_range();
        for (int k = 0; k < HIST_LEN; k++)
            history[k] = 8'h00;
        bytes_counted = '0;
        hit           = 1'b0;
        hit_offset    = '0;
        saturated     = 1'b0;
    endtask

    // One range byte: count it, test for a pattern ending on it, shift it in
    task automatic absorb_byte(input logic [7:0] b);
        int unsigned n;
        int unsigned age;
        logic [7:0]  seen;
        bit          ok;
        n = sig_len_used();
        if (bytes_counted == '1)
        begin
            // counter pinned: byte still enters the window but cannot end a match
            saturated = 1'b1;
        end
        else
        begin
            bytes_counted = bytes_counted + 1'b1;
            if (!hit && bytes_counted >= DEF_OFFSET_BITS'(n))
            begin
                ok = 1'b1;
                for (int unsigned j = 0; j < n; j++)
                begin
                    age  = n - 1 - j;
                    seen = (age == 0) ? b : history[age - 1];
                    if (care_mask[j] && seen != sig_byte(j))
                        ok = 1'b0;
                end
                if (ok)
                begin
                    hit        = 1'b1;
                    hit_offset = bytes_counted - DEF_OFFSET_BITS'(n);
                end
            end
        end
        for (int k = HIST_LEN - 1; k > 0; k--)
            history[k] = history[k - 1];
        history[0] = b;
    endtask

    task automatic take_word(input logic [DATA_W-1:0] w, input logic [COUNT_W-1:0] cnt,
                             input logic fin);
        int unsigned   n;
        scan_verdict_t v;
        n = (cnt > LANES) ? LANES : cnt;
        for (int unsigned k = 0; k < n; k++)
            absorb_byte(w[8 * k +: 8]);
        if (fin)
        begin
            v.hit      = hit;
            v.offset   = hit ? OUT_OFF_W'(hit_offset) : '0;
            v.too_long = saturated;
            verdicts_pending.push_back(v);
            clear_range();
        end
    endtask

    task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_PATTERN_LOW:    sig_words[0] = val;
            REG_PATTERN_MID:    sig_words[1] = val;
            REG_PATTERN_UPPER:  sig_words[2] = val;
            REG_PATTERN_TOP:    sig_words[3] = val;
            REG_CARE_BITS:      care_mask    = val[CARE_W-1:0];
            REG_PATTERN_LENGTH: sig_len_reg  = val[LENGTH_W-1:0];
            default:            ;  // unmapped index, no effect
        endcase
    endtask

    task automatic check_result();
        scan_verdict_t v;
        if (verdicts_pending.size() == 0)
        begin
            flag_mismatch($sformatf("result transfer with no range outstanding (found=%0b off=%0d)",
                                    found, match_offset));
        end
        else
        begin
            v = verdicts_pending.pop_front();
            if (found !== v.hit)
                flag_mismatch($sformatf("found %0b, predicted %0b", found, v.hit));
            if (match_offset !== v.offset)
                flag_mismatch($sformatf("match_offset %0d, predicted %0d", match_offset, v.offset));
            if (range_too_long !== v.too_long)
                flag_mismatch($sformatf("range_too_long %0b, predicted %0b",
                                        range_too_long, v.too_long));
            if (v.hit)
                hits_seen++;
        end
        results_checked++;
    endtask

    // Input transfers first, then results, then register writes (they apply
    // from the next word on)
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PAT_WORDS; k++)
                sig_words[k] = '0;
            care_mask   = '0;
            sig_len_reg = LENGTH_W'(1);
            clear_range();
            verdicts_pending.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                take_word(data_word, byte_count, last);
            if (out_valid && !out_stall)
                check_result();
            if (cfg_we)
                apply_reg(cfg_index, cfg_data);
        end
        results_due = verdicts_pending.size();
    end

endmodule

@@ tb/testbench.sv @@
// ============================================================================
// testbench: top level for the wildcard byte pattern search
// Drives config writes and byte ranges with planted, spoiled and truncated
// signatures under random sender gaps and receiver stalls; the checker
// predicts and compares, this module only makes stimulus and gives the verdict.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    import wbps_pkg::*;

    localparam int RANDOM_WORDS = 1250;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SIG_MAX      = DEF_MAX_PATTERN;

    // indexes past the register list; writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_HI = 3'd7;

    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   cfg_we         = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index      = '0;
    logic [CFG_DATA_W-1:0]  cfg_data       = '0;
    logic                   in_valid       = 1'b0;
    logic                   in_stall;
    logic [DATA_W-1:0]      data_word      = '0;
    logic [COUNT_W-1:0]     byte_count     = '0;
    logic                   last           = 1'b0;
    logic                   out_valid;
    logic                   out_stall      = 1'b0;
    logic                   found;
    logic [OUT_OFF_W-1:0]   match_offset;
    logic                   range_too_long;

    int results_due;
    int results_checked;
    int hits_seen;
    int mismatches;

    int send_gap_pct     = 0;
    int result_stall_pct = 0;
    int words_sent       = 0;
    int ranges_sent      = 0;
    int setups_loaded    = 0;
    int quiet_cycles     = 0;

    // local copy of the signature, used to plant it into ranges
    logic [7:0]  sig_bytes [0:SIG_MAX-1];
    int unsigned sig_len = 1;

    wildcard_byte_pattern_search_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_word      (data_word),
        .byte_count     (byte_count),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found          (found),
        .match_offset   (match_offset),
        .range_too_long (range_too_long)
    );

    wbps_scan_checker checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_word       (data_word),
        .byte_count      (byte_count),
        .last            (last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .found           (found),
        .match_offset    (match_offset),
        .range_too_long  (range_too_long),
        .results_due     (results_due),
        .results_checked (results_checked),
        .hits_seen       (hits_seen),
        .mismatches      (mismatches)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side back-pressure
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < result_stall_pct);

    // Watchdog: cycles without any transfer or register write
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [7:0] narrow_byte();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h5A;
            default: return 8'hA5;
        endcase
    endfunction

    // Present one word and hold it until the transfer happens
    task automatic send_word(input logic [DATA_W-1:0] w, input logic [COUNT_W-1:0] cnt,
                             input logic fin);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_word  <= w;
        byte_count <= cnt;
        last       <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // Wait until every range has reported and the pipeline has settled
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (results_due == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Write all six registers plus one unmapped index; junk in unused high bits
    task automatic load_setup(input logic [63:0] w0, input logic [63:0] w1,
                              input logic [63:0] w2, input logic [63:0] w3,
                              input logic [CARE_W-1:0] care, input logic [LENGTH_W-1:0] len);
        logic [63:0] w [0:3];
        w = '{w0, w1, w2, w3};
        write_reg(REG_PATTERN_LOW, w0);
        write_reg(REG_PATTERN_MID, w1);
        write_reg(REG_PATTERN_UPPER, w2);
        write_reg(REG_PATTERN_TOP, w3);
        write_reg(REG_CARE_BITS, {$urandom, care});
        write_reg(REG_PATTERN_LENGTH, {$urandom, 26'($urandom), len});
        write_reg($urandom_range(1) ? SPARE_INDEX_HI : SPARE_INDEX_LO, {$urandom, $urandom});
        cfg_we <= 1'b0;
        for (int k = 0; k < SIG_MAX; k++)
            sig_bytes[k] = w[k / 8][8 * (k % 8) +: 8];
        sig_len = (len == 0) ? 1 : (len > SIG_MAX) ? SIG_MAX : len;
        setups_loaded++;
    endtask

    task automatic pick_setup();
        logic [63:0]         w [0:3];
        logic [CARE_W-1:0]   care;
        logic [LENGTH_W-1:0] len;
        bit                  narrow;
        int                  r;
        narrow = ($urandom_range(99) < 40);
        for (int k = 0; k < 4; k++)
        begin
            w[k] = {$urandom, $urandom};
            if (narrow)
                for (int j = 0; j < 8; j++)
                    w[k][8 * j +: 8] = narrow_byte();
        end
        r = $urandom_range(99);
        if (r < 30)
            care = '1;
        else if (r < 65)
            care = $urandom;
        else if (r < 85)
            care = $urandom & $urandom;
        else
            care = '0;
        r = $urandom_range(99);
        if (r < 45)
            len = LENGTH_W'($urandom_range(1, 8));
        else if (r < 80)
            len = LENGTH_W'($urandom_range(9, 31));
        else if (r < 92)
            len = 6'd32;
        else if (r < 96)
            len = 6'd0;
        else
            len = LENGTH_W'($urandom_range(33, 63));
        load_setup(w[0], w[1], w[2], w[3], care, len);
    endtask

    // Stream one range of nbytes; optionally plant the signature (possibly
    // cut off by the range end) and spoil one of its bytes.
    // split_mode 0: full words; 1: random counts including empty and oversize.
    task automatic scan_range(input int nbytes, input int plant_at, input bit spoil,
                              input int split_mode);
        logic [7:0]        seq [$];
        logic [DATA_W-1:0] w;
        logic [COUNT_W-1:0] pick;
        int                pos;
        int                take;
        int                r;
        bit                from_sig;
        from_sig = $urandom_range(1);
        for (int k = 0; k < nbytes; k++)
            seq.push_back(from_sig ? sig_bytes[$urandom_range(sig_len - 1)] : 8'($urandom));
        if (plant_at >= 0)
        begin
            for (int k = 0; k < sig_len && plant_at + k < nbytes; k++)
                seq[plant_at + k] = sig_bytes[k];
            if (spoil)
            begin
                r = plant_at + $urandom_range(sig_len - 1);
                if (r < nbytes)
                    seq[r] = ~seq[r];
            end
        end
        ranges_sent++;
        if (nbytes == 0)
            send_word({$urandom, $urandom}, 4'd0, 1'b1);
        pos = 0;
        while (pos < nbytes)
        begin
            r = $urandom_range(99);
            if (split_mode == 0)
                pick = 4'd8;
            else if (r < 6)
                pick = 4'd0;
            else if (r < 12)
                pick = COUNT_W'($urandom_range(9, 15));
            else
                pick = COUNT_W'($urandom_range(1, 8));
            take = (pick > 8) ? 8 : pick;
            if (take > nbytes - pos)
            begin
                take = nbytes - pos;
                pick = COUNT_W'(take);
            end
            w = {$urandom, $urandom};
            for (int k = 0; k < take; k++)
                w[8 * k +: 8] = seq[pos + k];
            pos += take;
            if (pos == nbytes && split_mode != 0 && $urandom_range(9) == 0)
            begin
                // range closed by a trailing empty word
                send_word(w, pick, 1'b0);
                send_word({$urandom, $urandom}, 4'd0, 1'b1);
            end
            else
            begin
                send_word(w, pick, pos == nbytes);
            end
        end
    endtask

    initial
    begin
        int phase;
        int random_goal;
        int n;
        int plant_at;
        send_gap_pct     = 17;
        result_stall_pct = 63;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset setup is a one-byte wildcard, so any byte matches
        send_word('0, 4'd1, 1'b1);
        // empty range
        send_word('1, 4'd0, 1'b1);

        // length zero acts as one; oversize byte count acts as eight
        drain_results();
        load_setup('1, '1, '1, '1, '1, 6'd0);
        send_word('1, 4'd15, 1'b1);

        // length above the maximum saturates; match spanning words
        drain_results();
        load_setup({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, '1, 6'd63);
        scan_range(40, 5, 1'b0, 0);
        // pattern cut off by the range end must not count
        scan_range(20, 0, 1'b0, 0);

        // all wildcards, full length: needs 32 bytes in the range
        drain_results();
        load_setup({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, '0, 6'd32);
        scan_range(31, -1, 1'b0, 0);
        scan_range(32, -1, 1'b0, 0);

        // sparse care bits with ragged word counts
        drain_results();
        load_setup({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, 32'h5555_5555, 6'd9);
        scan_range(24, 13, 1'b0, 1);

        // Random: three idling profiles, new setup every few ranges
        random_goal = words_sent;
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_gap_pct     = 17;
                    result_stall_pct = 63;
                end
                1:
                begin
                    send_gap_pct     = 63;
                    result_stall_pct = 17;
                end
                default:
                begin
                    send_gap_pct     = 0;
                    result_stall_pct = 0;
                end
            endcase
            random_goal += RANDOM_WORDS / 3;
            while (words_sent < random_goal)
            begin
                drain_results();
                pick_setup();
                repeat ($urandom_range(3, 10))
                begin
                    if (words_sent < random_goal)
                    begin
                        n = $urandom_range(99);
                        if (n < 8)
                            n = $urandom_range(0, 3);
                        else if (n < 80)
                            n = $urandom_range(4, 40);
                        else
                            n = $urandom_range(41, 100);
                        plant_at = -1;
                        if (n > 0 && $urandom_range(99) < 65)
                            plant_at = (n >= sig_len) ? $urandom_range(n - sig_len)
                                                      : $urandom_range(n - 1);
                        scan_range(n, plant_at, $urandom_range(99) < 20,
                                   ($urandom_range(99) < 30) ? 0 : 1);
                    end
                end
            end
        end

        drain_results();
        repeat (4) @(posedge clk);
        $display("covered %0d words in %0d ranges over %0d pattern setups",
                 words_sent, ranges_sent, setups_loaded);
        $display("checked %0d results, %0d with a match found", results_checked, hits_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
hdl/wbps_pkg.sv
hdl/wbps_lane.sv
hdl/wbps_merge.sv
hdl/wildcard_byte_pattern_search_top.sv
tb/wbps_scan_checker.sv
tb/testbench.sv
